>>> sv/bpf_pkg.sv
package bpf_pkg;
  localparam int MaxDepth = 5;
  localparam int LvlW = 3;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic               last_segment;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } pnt_t;

  // job handed from front to back
  localparam logic [1:0] JOB_LINE2 = 2'd0;  // two closing lines
  localparam logic [1:0] JOB_CURVE = 2'd1;  // curve, no lead-in
  localparam logic [1:0] JOB_LEAD  = 2'd2;  // lead-in line then curve

  typedef struct packed {
    logic [1:0] kind;
    pnt_t       p0;    // pen
    pnt_t       s;     // lead-in end / closing mid point
    pnt_t       c1;
    pnt_t       c2;
    pnt_t       e;
  } job_t;

  // floor(v/3) for v in small signed range (|v| < 2^19)
  function automatic logic signed [15:0] div3(input logic signed [19:0] v);
    logic signed [41:0] p;
    logic signed [19:0] q;
    logic signed [19:0] r;
    p = v * 42'sd349526;           // ceil(2^20/3)
    q = 20'(p >>> 20);
    r = v - q * 20'sd3;
    if (r < 0) q = q - 20'sd1;
    else if (r >= 20'sd3) q = q + 20'sd1;
    return 16'(q);
  endfunction

  function automatic logic signed [15:0] div6(input logic signed [19:0] v);
    logic signed [41:0] p;
    logic signed [19:0] q;
    logic signed [19:0] r;
    p = v * 42'sd174763;           // ceil(2^20/6)
    q = 20'(p >>> 20);
    r = v - q * 20'sd6;
    if (r < 0) q = q - 20'sd1;
    else if (r >= 20'sd6) q = q + 20'sd1;
    return 16'(q);
  endfunction

  function automatic pnt_t half(input pnt_t a, input pnt_t b);
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    pnt_t r;
    sx = 17'(a.x) + 17'(b.x);
    sy = 17'(a.y) + 17'(b.y);
    r.x = sx[16:1];
    r.y = sy[16:1];
    return r;
  endfunction
endpackage

>>> sv/bpf_front.sv
module bpf_front import bpf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     job_valid,
  input  logic     job_stall,
  output job_t     job_data
);
  logic [1:0] phase_r, phase_nxt;
  pnt_t older_r, older_nxt, newer_r, newer_nxt, pen_r, pen_nxt;
  logic job_valid_r, job_valid_nxt;
  job_t job_r, job_nxt;
  pnt_t q, c1, c2, e, s;
  logic acc;

  assign in_stall  = job_valid_r;
  assign acc       = in_valid && !job_valid_r;
  assign job_valid = job_valid_r;
  assign job_data  = job_r;
  assign q.x = in_data.point_x;
  assign q.y = in_data.point_y;

  always_comb begin
    c1.x = div3(20'(older_r.x) * 20'sd2 + 20'(newer_r.x));
    c1.y = div3(20'(older_r.y) * 20'sd2 + 20'(newer_r.y));
    c2.x = div3(20'(older_r.x) + 20'(newer_r.x) * 20'sd2);
    c2.y = div3(20'(older_r.y) + 20'(newer_r.y) * 20'sd2);
    e.x  = div6(20'(older_r.x) + 20'(newer_r.x) * 20'sd4 + 20'(q.x));
    e.y  = div6(20'(older_r.y) + 20'(newer_r.y) * 20'sd4 + 20'(q.y));
    s.x  = div6(20'(older_r.x) * 20'sd5 + 20'(newer_r.x));
    s.y  = div6(20'(older_r.y) * 20'sd5 + 20'(newer_r.y));
  end

  always_comb begin
    phase_nxt = phase_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    pen_nxt   = pen_r;
    job_valid_nxt = job_valid_r && job_stall;
    job_nxt   = job_r;
    if (acc) begin
      unique case (in_data.operation)
        OP_BEGIN: begin
          phase_nxt = 2'd0;
          older_nxt = '0;
          newer_nxt = '0;
          pen_nxt   = '0;
        end
        OP_END: begin
          if (phase_r == 2'd3) begin
            job_valid_nxt = 1'b1;
            job_nxt = '{kind: JOB_LINE2, p0: pen_r, s: c2, c1: c1, c2: c2, e: newer_r};
          end
        end
        OP_ADD: begin
          older_nxt = newer_r;
          newer_nxt = q;
          unique case (phase_r)
            2'd0: begin
              phase_nxt = 2'd1;
              pen_nxt = q;
            end
            2'd1: phase_nxt = 2'd2;
            2'd2: begin
              phase_nxt = 2'd3;
              pen_nxt = e;
              job_valid_nxt = 1'b1;
              job_nxt = '{kind: JOB_LEAD, p0: pen_r, s: s, c1: c1, c2: c2, e: e};
            end
            default: begin
              pen_nxt = e;
              job_valid_nxt = 1'b1;
              job_nxt = '{kind: JOB_CURVE, p0: pen_r, s: s, c1: c1, c2: c2, e: e};
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      older_r <= '0;
      newer_r <= '0;
      pen_r <= '0;
      job_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      pen_r <= pen_nxt;
      job_valid_r <= job_valid_nxt;
    end
    job_r <= job_nxt;
  end
endmodule

>>> sv/bpf_fifo.sv
module bpf_fifo import bpf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_stall,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output job_t rd_data
);
  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr_en, rd_en;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr_en = wr_valid && !wr_stall;
  assign rd_en = rd_valid && !rd_stall;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule

>>> sv/bpf_back.sv
module bpf_back import bpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [11:0] flat_limit,
  input  logic      job_valid,
  output logic      job_stall,
  input  job_t      job_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LINE  = 3'd1;  // closing/lead-in lines
  localparam logic [2:0] S_MUL1  = 3'd2;  // differences stage
  localparam logic [2:0] S_MUL2  = 3'd3;  // products stage
  localparam logic [2:0] S_TEST  = 3'd4;  // cross products and chord length
  localparam logic [2:0] S_SQ    = 3'd5;  // squares and limit
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] st_r, st_nxt;
  job_t job_r;
  logic [1:0] line_cnt_r, line_cnt_nxt;
  pnt_t p0_r, c1_r, c2_r, p1_r, p0_nxt, c1_nxt, c2_nxt, p1_nxt;
  logic [LvlW-1:0] lvl_r, lvl_nxt;
  logic [2:0] sp_r, sp_nxt;
  pnt_t stk_s_r [MaxDepth];
  pnt_t stk_a_r [MaxDepth];
  pnt_t stk_b_r [MaxDepth];
  pnt_t stk_e_r [MaxDepth];
  logic [LvlW-1:0] stk_l_r [MaxDepth];
  logic push;
  logic [2:0] pop_idx;

  // flatness datapath
  logic signed [16:0] dx_r, dy_r, ax1_r, ay1_r, ax2_r, ay2_r;
  logic signed [33:0] m1a_r, m1b_r, m2a_r, m2b_r, ddx_r, ddy_r;
  logic [33:0] cr1_r, cr2_r;
  logic [34:0] len2_r;
  logic [23:0] t2_r;
  logic [63:0] sq1_r, sq2_r, lim_r;
  logic big1_r, big2_r, zero_r;
  logic flat;

  out_item_t ob_r, ob_nxt;
  logic ov_r, ov_nxt;
  pnt_t l1, hh, r2, l2, r1, mid;

  assign job_stall = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data = ob_r;

  assign l1 = half(p0_r, c1_r);
  assign hh = half(c1_r, c2_r);
  assign r2 = half(c2_r, p1_r);
  assign l2 = half(l1, hh);
  assign r1 = half(hh, r2);
  assign mid = half(l2, r1);
  assign pop_idx = sp_r - 3'd1;

  assign flat = zero_r ? (flat_limit != 12'd0)
              : (!big1_r && !big2_r && sq1_r < lim_r && sq2_r < lim_r);

  always_ff @(posedge clk) begin
    logic signed [33:0] c1v, c2v;
    // differences, settled at end of S_MUL1
    dx_r  <= 17'(p1_r.x) - 17'(p0_r.x);
    dy_r  <= 17'(p1_r.y) - 17'(p0_r.y);
    ax1_r <= 17'(c1_r.x) - 17'(p0_r.x);
    ay1_r <= 17'(c1_r.y) - 17'(p0_r.y);
    ax2_r <= 17'(c2_r.x) - 17'(p0_r.x);
    ay2_r <= 17'(c2_r.y) - 17'(p0_r.y);
    // products, settled at end of S_MUL2
    m1a_r <= ay1_r * dx_r;
    m1b_r <= ax1_r * dy_r;
    m2a_r <= ay2_r * dx_r;
    m2b_r <= ax2_r * dy_r;
    ddx_r <= dx_r * dx_r;
    ddy_r <= dy_r * dy_r;
    t2_r  <= 24'(flat_limit) * 24'(flat_limit);
    // settled at end of S_TEST
    c1v = m1a_r - m1b_r;
    c2v = m2a_r - m2b_r;
    cr1_r <= c1v[33] ? 34'(-c1v) : 34'(c1v);
    cr2_r <= c2v[33] ? 34'(-c2v) : 34'(c2v);
    len2_r <= 35'(ddx_r) + 35'(ddy_r);
    zero_r <= (dx_r == 17'sd0) && (dy_r == 17'sd0);
    // settled at end of S_SQ
    big1_r <= cr1_r[33:32] != 2'd0;
    big2_r <= cr2_r[33:32] != 2'd0;
    sq1_r <= cr1_r[31:0] * cr1_r[31:0];
    sq2_r <= cr2_r[31:0] * cr2_r[31:0];
    lim_r <= 64'(t2_r) * 64'(len2_r);
  end

  always_comb begin
    st_nxt = st_r;
    line_cnt_nxt = line_cnt_r;
    p0_nxt = p0_r; c1_nxt = c1_r; c2_nxt = c2_r; p1_nxt = p1_r;
    lvl_nxt = lvl_r;
    sp_nxt = sp_r;
    push = 1'b0;
    ov_nxt = ov_r && out_stall;
    ob_nxt = ob_r;
    unique case (st_r)
      S_IDLE: begin
        if (job_valid) begin
          p0_nxt = job_data.p0; c1_nxt = job_data.c1;
          c2_nxt = job_data.c2; p1_nxt = job_data.e;
          lvl_nxt = '0;
          sp_nxt = '0;
          line_cnt_nxt = '0;
          st_nxt = (job_data.kind == JOB_CURVE) ? S_MUL1 : S_LINE;
        end
      end
      S_LINE: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          if (job_r.kind == JOB_LINE2) begin
            if (line_cnt_r == 2'd0) begin
              ob_nxt = '{job_r.p0.x, job_r.p0.y, job_r.s.x, job_r.s.y, 1'b0};
              line_cnt_nxt = 2'd1;
            end else begin
              ob_nxt = '{job_r.s.x, job_r.s.y, job_r.e.x, job_r.e.y, 1'b1};
              st_nxt = S_IDLE;
            end
          end else begin
            ob_nxt = '{job_r.p0.x, job_r.p0.y, job_r.s.x, job_r.s.y, 1'b0};
            p0_nxt = job_r.s;
            st_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: st_nxt = S_MUL2;
      S_MUL2: st_nxt = S_TEST;
      S_TEST: st_nxt = S_SQ;
      S_SQ:   st_nxt = S_EMIT;
      default: begin  // S_EMIT: decide with settled flatness result
        if (32'(lvl_r) >= MaxDepth || flat) begin
          if (!ov_nxt) begin
            ov_nxt = 1'b1;
            ob_nxt = '{p0_r.x, p0_r.y, p1_r.x, p1_r.y, sp_r == 3'd0};
            if (sp_r == 3'd0) begin
              st_nxt = S_IDLE;
            end else begin
              sp_nxt = pop_idx;
              p0_nxt = stk_s_r[pop_idx];
              c1_nxt = stk_a_r[pop_idx];
              c2_nxt = stk_b_r[pop_idx];
              p1_nxt = stk_e_r[pop_idx];
              lvl_nxt = stk_l_r[pop_idx];
              st_nxt = S_MUL1;
            end
          end
        end else begin
          push = 1'b1;
          sp_nxt = sp_r + 3'd1;
          c1_nxt = l1; c2_nxt = l2; p1_nxt = mid;
          lvl_nxt = lvl_r + LvlW'(1);
          st_nxt = S_MUL1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    if (st_r == S_IDLE) job_r <= job_data;
    line_cnt_r <= line_cnt_nxt;
    p0_r <= p0_nxt; c1_r <= c1_nxt; c2_r <= c2_nxt; p1_r <= p1_nxt;
    lvl_r <= lvl_nxt;
    sp_r <= sp_nxt;
    ob_r <= ob_nxt;
    if (push) begin
      stk_s_r[sp_r] <= mid;
      stk_a_r[sp_r] <= r1;
      stk_b_r[sp_r] <= r2;
      stk_e_r[sp_r] <= p1_r;
      stk_l_r[sp_r] <= lvl_r + LvlW'(1);
    end
  end
endmodule

>>> sv/bspline_path_flattener_core.sv
// channel | ports                      | payload
// in      | in_valid / in_stall        | in_data  (in_item_t)
// out     | out_valid / out_stall      | out_data (out_item_t)
// cfg     | cfg_we / cfg_wdata         | flat_limit, 12 bits
// Each subdivision node of a curve piece passes the 4-stage flatness
// pipeline plus a decision state; a full split to depth 5 visits 63 nodes.
// Lines and the lead-in bypass the flatness pipeline, gated by out_stall.
// A two-entry queue between front and back lets points be taken while a
// curve is still being flattened. Synchronous reset clears control state.
module bspline_path_flattener_core import bpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [11:0] cfg_wdata
);
  logic [11:0] flat_limit_r;
  logic fj_valid, fj_stall, bj_valid, bj_stall;
  job_t fj_data, bj_data;

  always_ff @(posedge clk) begin
    if (!rst_n) flat_limit_r <= 12'd8;
    else if (cfg_we) flat_limit_r <= cfg_wdata;
  end

  bpf_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid(fj_valid), .job_stall(fj_stall), .job_data(fj_data)
  );

  bpf_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_data(fj_data),
    .rd_valid(bj_valid), .rd_stall(bj_stall), .rd_data(bj_data)
  );

  bpf_back u_back (
    .clk, .rst_n, .flat_limit(flat_limit_r),
    .job_valid(bj_valid), .job_stall(bj_stall), .job_data(bj_data),
    .out_valid, .out_stall, .out_data
  );
endmodule

>>> sv/bpf_checker.sv
module bpf_checker import bpf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");
  a_no_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_valid) && !$isunknown(in_stall))
    else $error("handshake signal unknown");
endmodule

bind bspline_path_flattener_core bpf_checker u_chk (.*);

>>> tb/bpf_segment_checker.sv
module bpf_segment_checker import bpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  output int          mismatches,
  output int          segs_waiting,
  output int          items_seen,
  output int          segs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [11:0] flat_limit;
  logic [1:0]  path_phase;
  pnt_t        older_pt, newer_pt, pen_pt;
  out_item_t   expected_segs[$];
  int          item_seg_cnt;

  function automatic logic signed [15:0] floor_div(input longint a, input longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return 16'(q);
  endfunction

  function automatic pnt_t mid_pt(input pnt_t a, input pnt_t b);
    pnt_t r;
    r.x = floor_div(longint'(a.x) + longint'(b.x), 2);
    r.y = floor_div(longint'(a.y) + longint'(b.y), 2);
    return r;
  endfunction

  function automatic bit ctrl_close(input pnt_t p0, input pnt_t c, input longint dx,
                                    input longint dy, input longint unsigned lim);
    longint cr;
    longint unsigned mag;
    cr = (longint'(c.y) - longint'(p0.y)) * dx - (longint'(c.x) - longint'(p0.x)) * dy;
    mag = (cr < 0) ? -cr : cr;
    if (mag >= 64'h1_0000_0000) return 1'b0;
    return (mag * mag) < lim;
  endfunction

  // squared distance test, no root or division
  function automatic bit piece_flat(input pnt_t p0, input pnt_t c1, input pnt_t c2,
                                    input pnt_t p1);
    longint dx, dy;
    longint unsigned len2, t, lim;
    dx = longint'(p1.x) - longint'(p0.x);
    dy = longint'(p1.y) - longint'(p0.y);
    if (dx == 0 && dy == 0) return flat_limit != 0;
    len2 = dx * dx + dy * dy;
    t = flat_limit;
    lim = t * t * len2;
    return ctrl_close(p0, c1, dx, dy, lim) && ctrl_close(p0, c2, dx, dy, lim);
  endfunction

  function automatic void push_seg(input pnt_t a, input pnt_t b);
    out_item_t s;
    if (item_seg_cnt >= 33) return;
    s.from_x = a.x;
    s.from_y = a.y;
    s.to_x = b.x;
    s.to_y = b.y;
    s.last_segment = 1'b0;
    expected_segs.push_back(s);
    item_seg_cnt++;
  endfunction

  function automatic void split_piece(input pnt_t p0, input pnt_t c1, input pnt_t c2,
                                      input pnt_t p1);
    pnt_t st_start[MaxDepth], st_a[MaxDepth], st_b[MaxDepth], st_end[MaxDepth];
    int   st_lvl[MaxDepth];
    int   lvl, sp;
    pnt_t l1, h, r1, r2, l2, m;
    lvl = 0;
    sp = 0;
    forever begin
      if (lvl >= MaxDepth || piece_flat(p0, c1, c2, p1)) begin
        push_seg(p0, p1);
        if (sp == 0) break;
        sp--;
        p0 = st_start[sp];
        c1 = st_a[sp];
        c2 = st_b[sp];
        p1 = st_end[sp];
        lvl = st_lvl[sp];
      end else begin
        l1 = mid_pt(p0, c1);
        h  = mid_pt(c1, c2);
        r2 = mid_pt(c2, p1);
        l2 = mid_pt(l1, h);
        r1 = mid_pt(h, r2);
        m  = mid_pt(l2, r1);
        if (sp < MaxDepth) begin
          st_start[sp] = m;
          st_a[sp] = r1;
          st_b[sp] = r2;
          st_end[sp] = p1;
          st_lvl[sp] = lvl + 1;
          sp++;
        end
        c1 = l1;
        c2 = l2;
        p1 = m;
        lvl++;
      end
    end
  endfunction

  function automatic void predict_segments(input in_item_t it);
    pnt_t q, a, b, pen, s, c1, c2, e;
    int   first;
    first = expected_segs.size();
    item_seg_cnt = 0;
    q.x = it.point_x;
    q.y = it.point_y;
    a = older_pt;
    b = newer_pt;
    pen = pen_pt;
    if (it.operation == OP_BEGIN) begin
      path_phase = 2'd0;
      older_pt = '0;
      newer_pt = '0;
      pen_pt = '0;
    end else if (it.operation == OP_END) begin
      if (path_phase == 2'd3) begin
        e.x = floor_div(longint'(a.x) + 2 * longint'(b.x), 3);
        e.y = floor_div(longint'(a.y) + 2 * longint'(b.y), 3);
        push_seg(pen, e);
        push_seg(e, b);
      end
    end else if (it.operation == OP_ADD) begin
      if (path_phase == 2'd0) begin
        path_phase = 2'd1;
        pen = q;
      end else if (path_phase == 2'd1) begin
        path_phase = 2'd2;
      end else begin
        if (path_phase == 2'd2) begin
          s.x = floor_div(5 * longint'(a.x) + longint'(b.x), 6);
          s.y = floor_div(5 * longint'(a.y) + longint'(b.y), 6);
          push_seg(pen, s);
          pen = s;
          path_phase = 2'd3;
        end
        c1.x = floor_div(2 * longint'(a.x) + longint'(b.x), 3);
        c1.y = floor_div(2 * longint'(a.y) + longint'(b.y), 3);
        c2.x = floor_div(longint'(a.x) + 2 * longint'(b.x), 3);
        c2.y = floor_div(longint'(a.y) + 2 * longint'(b.y), 3);
        e.x = floor_div(longint'(a.x) + 4 * longint'(b.x) + longint'(q.x), 6);
        e.y = floor_div(longint'(a.y) + 4 * longint'(b.y) + longint'(q.y), 6);
        split_piece(pen, c1, c2, e);
        pen = e;
      end
      older_pt = newer_pt;
      newer_pt = q;
      pen_pt = pen;
    end
    // operation code 3 falls through: ignored
    if (expected_segs.size() > first)
      expected_segs[expected_segs.size() - 1].last_segment = 1'b1;
  endfunction

  task automatic report(input string what);
    $display("[%0t] segment mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      flat_limit <= 12'd8;
      path_phase = 2'd0;
      older_pt = '0;
      newer_pt = '0;
      pen_pt = '0;
    end else begin
      if (cfg_we) flat_limit <= cfg_wdata;
      if (in_valid && !in_stall) begin
        predict_segments(in_data);
        items_seen++;
      end
      if (out_valid && !out_stall) begin
        segs_seen++;
        if (expected_segs.size() == 0) begin
          report($sformatf("unexpected segment (%0d,%0d)->(%0d,%0d)", out_data.from_x,
                           out_data.from_y, out_data.to_x, out_data.to_y));
        end else begin
          want = expected_segs.pop_front();
          if (out_data.from_x !== want.from_x)
            report($sformatf("from_x %0d, want %0d", out_data.from_x, want.from_x));
          if (out_data.from_y !== want.from_y)
            report($sformatf("from_y %0d, want %0d", out_data.from_y, want.from_y));
          if (out_data.to_x !== want.to_x)
            report($sformatf("to_x %0d, want %0d", out_data.to_x, want.to_x));
          if (out_data.to_y !== want.to_y)
            report($sformatf("to_y %0d, want %0d", out_data.to_y, want.to_y));
          if (out_data.last_segment !== want.last_segment)
            report($sformatf("last_segment %0b, want %0b", out_data.last_segment,
                             want.last_segment));
        end
      end
    end
    segs_waiting <= expected_segs.size();
  end

  initial begin
    mismatches = 0;
    items_seen = 0;
    segs_seen = 0;
    segs_waiting = 0;
  end
endmodule

>>> tb/tb_bspline_path_flattener_core.sv
module tb_bspline_path_flattener_core;
  import bpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [11:0] cfg_wdata;

  int mismatches, segs_waiting, items_seen, segs_seen;
  int cycles;
  int limits_used;
  bit in_burst, out_burst;

  bspline_path_flattener_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  bpf_segment_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .segs_waiting(segs_waiting),
    .items_seen(items_seen), .segs_seen(segs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d segments outstanding", cycles, segs_waiting);
      $display("Mismatches found");
      $finish;
    end
  end

  // item sender: random gap, then hold until taken
  task automatic send_item(input logic [1:0] op, input logic signed [15:0] x,
                           input logic signed [15:0] y);
    int  gap;
    bit  taken;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.operation <= op;
    in_data.point_x <= x;
    in_data.point_y <= y;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic add_pt(input int x, input int y);
    send_item(OP_ADD, 16'(x), 16'(y));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (segs_waiting != 0);
    // an ignored or silent item may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [11:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limits_used++;
  endtask

  // one random path, at times without begin or end and broken up by noise
  task automatic random_path(input int npts, input int spread, inout int sent);
    int cx, cy, x, y;
    cx = $urandom_range(0, 65535) - 32768;
    cy = $urandom_range(0, 65535) - 32768;
    if ($urandom_range(0, 9) != 0) begin
      send_item(OP_BEGIN, 16'($urandom), 16'($urandom));
      sent++;
    end
    for (int i = 0; i < npts; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        x = $urandom_range(0, 65535) - 32768;
        y = $urandom_range(0, 65535) - 32768;
      end else begin
        x = cx + $urandom_range(0, 2 * spread) - spread;
        y = cy + $urandom_range(0, 2 * spread) - spread;
        x = (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
        y = (y > 32767) ? 32767 : (y < -32768) ? -32768 : y;
      end
      cx = x;
      cy = y;
      add_pt(x, y);
      sent++;
      if ($urandom_range(0, 11) == 0) begin
        send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
        sent++;
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      send_item(OP_END, 16'($urandom), 16'($urandom));
      sent++;
    end
  endtask

  task automatic in_out_modes();
    forever begin
      repeat ($urandom_range(20, 200)) @(posedge clk);
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    in_out_modes();
  end

  // result side stall pattern
  initial begin
    int  w;
    bit  taken;
    out_stall <= 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      w = out_burst ? 0 : $urandom_range(0, 7);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        taken = out_valid;
        @(posedge clk);
      end while (!taken);
    end
  end

  initial begin
    int sent;
    int lim;
    cycles = 0;
    limits_used = 0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default threshold
    send_item(OP_NONE, 16'h7fff, 16'h8000);
    send_item(OP_END, 16'h1234, 16'hfedc);
    add_pt(-32768, -32768);
    add_pt(32767, 32767);
    add_pt(-32768, 32767);
    add_pt(0, 0);
    add_pt(32767, -32768);
    send_item(OP_END, 16'hffff, 16'h0000);
    add_pt(100, 100);
    send_item(OP_NONE, 16'h0000, 16'hffff);
    send_item(OP_END, 16'h5a5a, 16'ha5a5);
    send_item(OP_BEGIN, 16'hffff, 16'hffff);
    add_pt(5, 5);
    add_pt(5, 5);
    add_pt(5, 5);
    add_pt(5, 5);
    send_item(OP_END, 16'h0000, 16'h0000);

    // zero threshold: every piece splits to full depth
    set_limit(12'd0);
    send_item(OP_BEGIN, 16'h0, 16'h0);
    add_pt(-32768, 0);
    add_pt(32767, -32768);
    add_pt(0, 32767);
    add_pt(7, 7);
    add_pt(7, 7);
    send_item(OP_END, 16'h0, 16'h0);

    set_limit(12'd4095);
    send_item(OP_BEGIN, 16'h0, 16'h0);
    add_pt(-32768, -32768);
    add_pt(32767, -32768);
    add_pt(32767, 32767);
    add_pt(-32768, 32767);
    send_item(OP_END, 16'h0, 16'h0);

    // random part
    sent = 0;
    for (int ph = 0; ph < 9 && sent < 400; ph++) begin
      case (ph % 4)
        0: lim = $urandom_range(1, 16);
        1: lim = $urandom_range(17, 4095);
        2: lim = (ph == 2) ? 0 : 4095;
        default: lim = $urandom_range(0, 4095);
      endcase
      set_limit(12'(lim));
      while (sent < (ph + 1) * 46 && sent < 400) begin
        case ($urandom_range(0, 3))
          0: random_path($urandom_range(1, 10), 64, sent);
          1: random_path($urandom_range(3, 10), 1024, sent);
          2: random_path($urandom_range(3, 8), 16, sent);
          default: random_path($urandom_range(2, 6), 32767, sent);
        endcase
      end
    end
    set_limit(12'd8);

    wait_drained();
    $display("Covered %0d path items and %0d segments under %0d threshold settings.",
             items_seen, segs_seen, limits_used + 1);
    if (mismatches == 0 && segs_waiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d segments never arrived", mismatches, segs_waiting);
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

>>> files.f
sv/bpf_pkg.sv
sv/bpf_front.sv
sv/bpf_fifo.sv
sv/bpf_back.sv
sv/bspline_path_flattener_core.sv
sv/bpf_checker.sv
tb/bpf_segment_checker.sv
tb/tb_bspline_path_flattener_core.sv
